@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the relocation encoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle check, sampled on clk, off while rst_n is low.
`define SRDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle check: when ante holds, cons must hold at the next clock.
`define SRDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/srde_pkg.sv @@
// ----------------------------------------------------------------------------
// srde_pkg
// Types, constants and helper functions of the sorted relocation encoder.
// ----------------------------------------------------------------------------
package srde_pkg;

  localparam int unsigned TABLE_DEPTH   = 1024;
  localparam int unsigned IDX_W         = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned WADDR_W       = 30;
  localparam int unsigned MODE_W        = 8;
  localparam int unsigned ENTRY_W       = WADDR_W + MODE_W;
  localparam int unsigned BADDR_W       = 32;
  localparam int unsigned DELTA_W       = 32;
  localparam int unsigned ENTRY_COUNT_W = 11;
  localparam int unsigned HEADER_W      = 8;
  localparam int unsigned DBYTES_W      = 3;
  localparam int unsigned CLASS_W       = 2;
  localparam int unsigned CLASS_SHIFT   = 6;

  // Stream word layout.
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned OUT_TUSER_W = 3;
  localparam int unsigned OUT_USED_W  = ENTRY_COUNT_W + HEADER_W + DELTA_W + DBYTES_W;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;
  localparam int unsigned IN_FLAG_LSB = BADDR_W;

  // Delta size limits.
  localparam logic [DELTA_W-1:0] DELTA_LIMIT_1B = DELTA_W'(256);
  localparam logic [DELTA_W-1:0] DELTA_LIMIT_2B = DELTA_W'(65536);

  localparam logic [DBYTES_W-1:0] DBYTES_NONE = 3'd0;
  localparam logic [DBYTES_W-1:0] DBYTES_1    = 3'd1;
  localparam logic [DBYTES_W-1:0] DBYTES_2    = 3'd2;
  localparam logic [DBYTES_W-1:0] DBYTES_4    = 3'd4;

  localparam logic [CLASS_W-1:0] CLASS_1B = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_2B = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_4B = 2'd2;

  // Mode map; the third entry is minus one held in eight bits.
  localparam logic [MODE_W-1:0] MODE_MAP [8] = '{
    8'd0, 8'd1, 8'hFF, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6
  };

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_MISALIGNED = 2'd1,
    STAT_FULL       = 2'd2,
    STAT_PAST_END   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_WR,
    S_RD_DATA,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [WADDR_W-1:0] waddr;
    logic [MODE_W-1:0]  mode;
  } entry_t;

  // Result of the shared subtract unit.
  typedef struct packed {
    logic [DELTA_W-1:0]  diff;
    logic                borrow;
    logic [CLASS_W-1:0]  size_class;
    logic [DBYTES_W-1:0] delta_bytes;
  } sub_res_t;

  typedef struct packed {
    status_t                  status;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     record_valid;
    logic [HEADER_W-1:0]      header_byte;
    logic [DELTA_W-1:0]       delta;
    logic [DBYTES_W-1:0]      delta_bytes;
    logic                     last;
  } res_t;

  function automatic logic [MODE_W-1:0] derive_mode(
    input logic undef,
    input logic absl,
    input logic spl,
    input logic sext
  );
    logic [2:0] idx;
    idx = undef ? (absl ? 3'd1 : 3'd3) : (absl ? 3'd0 : 3'd2);
    idx = idx + (spl ? 3'd4 : 3'd0) + (sext ? 3'd2 : 3'd0);
    return MODE_MAP[idx];
  endfunction

endpackage

@@ hw/rtl/srde_ram.sv @@
// ----------------------------------------------------------------------------
// srde_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module srde_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/srde_sub.sv @@
// ----------------------------------------------------------------------------
// srde_sub
// Shared subtractor: insert-order compare and readout delta with size class.
// ----------------------------------------------------------------------------
module srde_sub (
  input  logic [srde_pkg::DELTA_W-1:0] a,
  input  logic [srde_pkg::DELTA_W-1:0] b,
  output srde_pkg::sub_res_t           res
);
  import srde_pkg::*;

  logic [DELTA_W:0] wide;

  // The extra top bit of the widened difference is the borrow, i.e. a < b.
  assign wide = {1'b0, a} - {1'b0, b};

  always_comb begin
    res.diff   = wide[DELTA_W-1:0];
    res.borrow = wide[DELTA_W];
    if (wide[DELTA_W-1:0] < DELTA_LIMIT_1B) begin
      res.size_class  = CLASS_1B;
      res.delta_bytes = DBYTES_1;
    end else if (wide[DELTA_W-1:0] < DELTA_LIMIT_2B) begin
      res.size_class  = CLASS_2B;
      res.delta_bytes = DBYTES_2;
    end else begin
      res.size_class  = CLASS_4B;
      res.delta_bytes = DBYTES_4;
    end
  end

endmodule

@@ hw/rtl/sorted_reloc_delta_encoder.sv @@
// A clear, an unused command, a refused insert, a read past the end and an insert into an
// empty table go from accept straight to S_RESP; a read passes S_RD_DATA first, and any
// other insert S_INS_CMP, which moves larger stored entries up one slot (one RAM read and
// write each), then S_INS_WR if every entry moved. S_RESP loads the result word once the
// output register is free; only then does S_IDLE take the next word, one word at a time.
// Reset clears the sequencer, count, read cursor and previous address; the table RAM is not.
// ----------------------------------------------------------------------------
// sorted_reloc_delta_encoder
// Sorted relocation table with delta-encoded readout.
// ----------------------------------------------------------------------------
module sorted_reloc_delta_encoder (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata: byte_address[31:0], symbol_undefined[32], absolute[33], split[34],
  //           sign_extend[35], zero pad[39:36]
  input  logic [srde_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: command[1:0]
  input  logic [srde_pkg::IN_TUSER_W-1:0]   in_tuser,
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata: entry_count[10:0], header_byte[18:11], delta[50:19],
  //            delta_bytes[53:51], zero pad[55:54]
  output logic [srde_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // out_tuser: status[1:0], record_valid[2]
  output logic [srde_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                              out_tlast
);
  import srde_pkg::*;

  // Sequencer and architectural state.
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   cursor_r, cursor_nxt;
  logic [WADDR_W-1:0] prev_r, prev_nxt;

  // Item being inserted and the slot it currently looks at.
  entry_t             new_r, new_nxt;
  logic               misal_r, misal_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  // Result waiting for the output register, and the output register itself.
  res_t               res_r, res_nxt;
  res_t               out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Table RAM ports.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;

  // Shared subtract unit.
  logic [DELTA_W-1:0] sub_a, sub_b;
  sub_res_t           sub_res;

  cmd_t               in_cmd;
  logic               accept;

  assign in_cmd    = cmd_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign rd_entry  = entry_t'(ram_rdata);

  srde_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The subtractor compares the new address with a stored one while shifting,
  // and forms the readout delta against the previously emitted address otherwise.
  always_comb begin
    if (state_r == S_INS_CMP) begin
      sub_a = DELTA_W'(new_r.waddr);
      sub_b = DELTA_W'(rd_entry.waddr);
    end else begin
      sub_a = DELTA_W'(rd_entry.waddr);
      sub_b = DELTA_W'(prev_r);
    end
  end

  srde_sub u_sub (
    .a   (sub_a),
    .b   (sub_b),
    .res (sub_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_r   <= new_nxt;
    misal_r <= misal_nxt;
    idx_r   <= idx_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  // Sequencer. An insert starts at the top of the table and walks down: each
  // cycle it compares the new address with the entry read in the cycle before,
  // moves that entry up one slot if it is strictly larger, and reads the next
  // one down. Equal addresses stop the walk, which keeps arrival order.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    prev_nxt      = prev_r;
    new_nxt       = new_r;
    misal_nxt     = misal_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = new_r;
    ram_re        = 1'b0;
    ram_raddr     = idx_r - IDX_W'(1);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          new_nxt.waddr        = in_tdata[BADDR_W-1:2];
          new_nxt.mode         = derive_mode(in_tdata[IN_FLAG_LSB], in_tdata[IN_FLAG_LSB + 1],
                                             in_tdata[IN_FLAG_LSB + 2],
                                             in_tdata[IN_FLAG_LSB + 3]);
          misal_nxt            = (in_tdata[1:0] != 2'b00);
          res_nxt.status       = STAT_OK;
          res_nxt.entry_count  = '0;
          res_nxt.record_valid = 1'b0;
          res_nxt.header_byte  = '0;
          res_nxt.delta        = '0;
          res_nxt.delta_bytes  = DBYTES_NONE;
          res_nxt.last         = 1'b0;
          state_nxt            = S_RESP;
          unique case (in_cmd)
            CMD_INSERT: begin
              if (count_r >= CNT_W'(TABLE_DEPTH)) begin
                res_nxt.status = STAT_FULL;
              end else if (count_r == '0) begin
                // Empty table: the entry goes straight into slot zero.
                ram_we         = 1'b1;
                ram_waddr      = '0;
                ram_wdata      = new_nxt;
                count_nxt      = count_r + CNT_W'(1);
                res_nxt.status = misal_nxt ? STAT_MISALIGNED : STAT_OK;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(count_r - CNT_W'(1));
                idx_nxt   = IDX_W'(count_r);
                state_nxt = S_INS_CMP;
              end
            end
            CMD_READ: begin
              if (cursor_r >= count_r) begin
                res_nxt.status = STAT_PAST_END;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(cursor_r);
                state_nxt = S_RD_DATA;
              end
            end
            CMD_CLEAR: begin
              count_nxt  = '0;
              cursor_nxt = '0;
              prev_nxt   = '0;
            end
            CMD_NONE: begin
              state_nxt = S_RESP;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_INS_CMP: begin
        ram_we = 1'b1;
        if (sub_res.borrow) begin
          // Stored entry is larger: move it up and fetch the one below.
          ram_wdata = rd_entry;
          idx_nxt   = idx_r - IDX_W'(1);
          if (idx_r == IDX_W'(1)) begin
            state_nxt = S_INS_WR;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r - IDX_W'(2);
          end
        end else begin
          ram_wdata      = new_r;
          count_nxt      = count_r + CNT_W'(1);
          res_nxt.status = misal_r ? STAT_MISALIGNED : STAT_OK;
          state_nxt      = S_RESP;
        end
      end

      S_INS_WR: begin
        // Every stored entry moved up; the new one lands in slot zero.
        ram_we         = 1'b1;
        ram_wdata      = new_r;
        count_nxt      = count_r + CNT_W'(1);
        res_nxt.status = misal_r ? STAT_MISALIGNED : STAT_OK;
        state_nxt      = S_RESP;
      end

      S_RD_DATA: begin
        res_nxt.record_valid = 1'b1;
        res_nxt.header_byte  = HEADER_W'({sub_res.size_class, {CLASS_SHIFT{1'b0}}})
                               | rd_entry.mode;
        res_nxt.delta        = sub_res.diff;
        res_nxt.delta_bytes  = sub_res.delta_bytes;
        res_nxt.last         = ((cursor_r + CNT_W'(1)) == count_r);
        prev_nxt             = rd_entry.waddr;
        cursor_nxt           = cursor_r + CNT_W'(1);
        state_nxt            = S_RESP;
      end

      S_RESP: begin
        // Wait for the output register to be free, then hand the result over
        // with the count as it stands after this command.
        if (!out_valid_r || out_tready) begin
          out_nxt             = res_r;
          out_nxt.entry_count = ENTRY_COUNT_W'(count_r);
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_r.delta_bytes, out_r.delta, out_r.header_byte,
                       out_r.entry_count};
  assign out_tuser  = {out_r.record_valid, out_r.status};
  assign out_tlast  = out_r.last;

endmodule

@@ hw/rtl/srde_checker.sv @@
// ----------------------------------------------------------------------------
// srde_checker
// Port-level assertions for the sorted relocation encoder, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srde_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [srde_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [srde_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input logic                              out_tlast
);
  import srde_pkg::*;

  logic                rec;
  logic [DBYTES_W-1:0] dbytes;
  logic                in_word_seen;
  logic                dbytes_legal;
  logic                rec_ok;

  assign rec          = out_tuser[2];
  assign dbytes       = out_tdata[53:51];
  assign in_word_seen = in_tvalid && in_tready;
  assign dbytes_legal = (dbytes == DBYTES_1) || (dbytes == DBYTES_2) || (dbytes == DBYTES_4);
  assign rec_ok       = (out_tuser[1:0] == STAT_OK) && dbytes_legal;

  // A result word that is not taken stays put.
  `SRDE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word changed while stalled")

  // The block works on one word at a time: after an accept it is busy.
  `SRDE_ASSERT_NEXT(a_busy_after_accept, in_word_seen, !in_tready, "ready right after an accept")

  // A record always reports status ok and a legal delta size.
  `SRDE_ASSERT(a_rec_fields, !(out_tvalid && rec) || rec_ok, "record with bad status or size")

  // Without a record the delta size and the last flag are zero.
  `SRDE_ASSERT(a_norec_fields, !(out_tvalid && !rec) || (dbytes == DBYTES_NONE && !out_tlast), "stray record fields")

endmodule

bind sorted_reloc_delta_encoder srde_checker u_srde_checker (.*);
